// ===== design/top_n_min_heap_core_defines.svh =====
// assertion macros for the top-n min-heap core
`ifndef TOP_N_MIN_HEAP_CORE_DEFINES_SVH
`define TOP_N_MIN_HEAP_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define TNH_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define TNH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/tnh_pkg.sv =====
// types, codes and constants of the top-n min-heap core
package tnh_pkg;

    localparam int HEAP_DEPTH_DEF = 16;
    localparam logic [4:0] CAP_RESET = 5'd16;

    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_DRAIN = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] weight;
        logic [31:0] tag;
    } req_t;

    typedef struct packed {
        logic [31:0] out_weight;
        logic [31:0] out_tag;
        logic [3:0]  rank;
        logic        is_last;
        logic        empty_res;
    } res_t;

    typedef struct packed {
        logic [31:0] weight;
        logic [31:0] tag;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_CHK,
        ST_UP,
        ST_UP_CMP,
        ST_DN_L,
        ST_DN_R,
        ST_DN_CMP,
        ST_DR_ROOT,
        ST_DR_LAST,
        ST_DR_POP
    } state_t;

    typedef struct packed {
        logic [6:0] fill;
        logic       idle;
    } stat_t;

endpackage

// ===== design/tnh_ram.sv =====
// generic simple dual-port ram with registered read
module tnh_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/tnh_ctrl.sv =====
// heap sequencer: add with sift up or root replace, drain, clear
module tnh_ctrl #(
    parameter int HEAP_DEPTH = tnh_pkg::HEAP_DEPTH_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        start,
    input  tnh_pkg::req_t                               req,
    output logic                                        busy,
    input  logic [$clog2(HEAP_DEPTH+1)-1:0]             eff_cap,
    output logic                                        done,
    output tnh_pkg::res_t                               res,
    output tnh_pkg::stat_t                              stat
);
    import tnh_pkg::*;

    localparam int FW = $clog2(HEAP_DEPTH + 1);
    localparam int AW = HEAP_DEPTH > 1 ? $clog2(HEAP_DEPTH) : 1;

    state_t          state_reg, state_next;
    logic [FW-1:0]   fill_reg, fill_next;
    logic [FW-1:0]   pos_reg, pos_next;
    entry_t          m_reg, m_next;
    entry_t          lchild_reg, lchild_next;
    logic            rok_reg, rok_next;
    logic            drain_reg, drain_next;
    entry_t          top_reg, top_next;
    res_t            res_reg, res_next;
    logic            done_reg, done_next;

    logic            rd_en, wr_en;
    logic [AW-1:0]   rd_addr, wr_addr;
    entry_t          wr_data, rd_data;
    logic [63:0]     rd_raw;

    logic [FW:0]     lpos, rpos, fill_x;
    logic [FW-1:0]   ppos;
    entry_t          chosen;
    logic [FW-1:0]   cpos;
    state_t          after_sift;

    assign lpos    = {pos_reg, 1'b1};
    assign rpos    = lpos + (FW+1)'(1);
    assign fill_x  = {1'b0, fill_reg};
    assign ppos    = (pos_reg - FW'(1)) >> 1;
    assign rd_data = entry_t'(rd_raw);

    always_comb
    begin
        if (!rok_reg || (lchild_reg.weight < rd_data.weight))
        begin
            chosen = lchild_reg;
            cpos   = lpos[FW-1:0];
        end
        else
        begin
            chosen = rd_data;
            cpos   = rpos[FW-1:0];
        end
    end

    // a drain keeps popping until the heap runs dry
    assign after_sift = (drain_reg && (fill_reg != '0)) ? ST_DR_ROOT : ST_IDLE;

    tnh_ram #(
        .WIDTH (64),
        .DEPTH (HEAP_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_raw)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            drain_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            drain_reg <= drain_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        m_reg      <= m_next;
        lchild_reg <= lchild_next;
        rok_reg    <= rok_next;
        top_reg    <= top_next;
        res_reg    <= res_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        pos_next    = pos_reg;
        m_next      = m_reg;
        lchild_next = lchild_reg;
        rok_next    = rok_reg;
        drain_next  = drain_reg;
        top_next    = top_reg;
        res_next    = res_reg;
        done_next   = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = pos_reg[AW-1:0];
        wr_data     = m_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                drain_next = 1'b0;
                if (start)
                begin
                    unique case (req.req_type)
                        REQ_ADD:
                        begin
                            m_next = '{weight: req.weight, tag: req.tag};
                            if (fill_reg >= eff_cap)
                            begin
                                rd_en      = 1'b1;
                                state_next = ST_ADD_CHK;
                            end
                            else
                            begin
                                pos_next   = fill_reg;
                                fill_next  = fill_reg + FW'(1);
                                state_next = ST_UP;
                            end
                        end
                        REQ_DRAIN:
                        begin
                            if (fill_reg == '0)
                            begin
                                res_next  = '{default: '0, empty_res: 1'b1};
                                done_next = 1'b1;
                            end
                            else
                            begin
                                drain_next = 1'b1;
                                rd_en      = 1'b1;
                                state_next = ST_DR_LAST;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            fill_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_ADD_CHK:
            begin
                // root heavier than the new item: drop it
                if (rd_data.weight > m_reg.weight)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    pos_next   = '0;
                    state_next = ST_DN_L;
                end
            end
            ST_UP:
            begin
                if (pos_reg == '0)
                begin
                    wr_en      = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = ppos[AW-1:0];
                    state_next = ST_UP_CMP;
                end
            end
            ST_UP_CMP:
            begin
                wr_en = 1'b1;
                if (m_reg.weight < rd_data.weight)
                begin
                    wr_data    = rd_data;
                    pos_next   = ppos;
                    state_next = ST_UP;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DN_L:
            begin
                if (lpos >= fill_x)
                begin
                    wr_en      = 1'b1;
                    state_next = after_sift;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = lpos[AW-1:0];
                    state_next = ST_DN_R;
                end
            end
            ST_DN_R:
            begin
                lchild_next = rd_data;
                rok_next    = rpos < fill_x;
                if (rpos < fill_x)
                begin
                    rd_en   = 1'b1;
                    rd_addr = rpos[AW-1:0];
                end
                state_next = ST_DN_CMP;
            end
            ST_DN_CMP:
            begin
                wr_en = 1'b1;
                if (chosen.weight > m_reg.weight)
                begin
                    state_next = after_sift;
                end
                else
                begin
                    wr_data    = chosen;
                    pos_next   = cpos;
                    state_next = ST_DN_L;
                end
            end
            ST_DR_ROOT:
            begin
                rd_en      = 1'b1;
                state_next = ST_DR_LAST;
            end
            ST_DR_LAST:
            begin
                top_next   = rd_data;
                rd_en      = 1'b1;
                rd_addr    = AW'(fill_reg - FW'(1));
                state_next = ST_DR_POP;
            end
            ST_DR_POP:
            begin
                // only the heaviest eff_cap entries are reported
                if (fill_reg <= eff_cap)
                begin
                    res_next.out_weight = top_reg.weight;
                    res_next.out_tag    = top_reg.tag;
                    res_next.rank       = 4'(fill_reg - FW'(1));
                    res_next.is_last    = fill_reg == FW'(1);
                    res_next.empty_res  = 1'b0;
                    done_next           = 1'b1;
                end
                m_next     = rd_data;
                fill_next  = fill_reg - FW'(1);
                pos_next   = '0;
                state_next = ST_DN_L;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy      = state_reg != ST_IDLE;
    assign done      = done_reg;
    assign res       = res_reg;
    assign stat.fill = 7'(fill_reg);
    assign stat.idle = state_reg == ST_IDLE;

endmodule

// ===== design/top_n_min_heap_core.sv =====
// top-n min-heap core: capacity register and heap sequencer
//
// channel   signals                 handshake
// request   start, req, busy        taken when start && !busy
// result    done, res               one-cycle strobe, no back-pressure
// config    cfg_we, cfg_data        capacity written when cfg_we
//
// an add sifts up per level (read parent, compare and write) or, when full, checks the
// root and sifts down per level (read left child, read right child, compare); a drain
// reads the root and the last entry for each pop, then sifts down
// the heap memory has one read and one write port; every level waits on its read
// reset clears fill count, capacity to 16; heap memory contents need no reset
// busy holds off requests while an item is at work; results are never stalled
module top_n_min_heap_core #(
    parameter int HEAP_DEPTH = tnh_pkg::HEAP_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  tnh_pkg::req_t  req,
    output logic           busy,
    output logic           done,
    output tnh_pkg::res_t  res,
    input  logic           cfg_we,
    input  logic [4:0]     cfg_data
);
    import tnh_pkg::*;

    `include "top_n_min_heap_core_defines.svh"

    localparam int FW = $clog2(HEAP_DEPTH + 1);

    logic [4:0]    capacity_reg;
    logic [FW-1:0] eff_cap;
    stat_t         stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_we)
        begin
            capacity_reg <= cfg_data;
        end
    end

    // zero acts as one, anything beyond the memory acts as the memory depth
    always_comb
    begin
        if (capacity_reg == 5'd0)
        begin
            eff_cap = FW'(1);
        end
        else if (int'(capacity_reg) > HEAP_DEPTH)
        begin
            eff_cap = FW'(HEAP_DEPTH);
        end
        else
        begin
            eff_cap = FW'(capacity_reg);
        end
    end

    tnh_ctrl #(
        .HEAP_DEPTH (HEAP_DEPTH)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .req     (req),
        .busy    (busy),
        .eff_cap (eff_cap),
        .done    (done),
        .res     (res),
        .stat    (stat)
    );

    `TNH_ASSERT_NOW(a_fill_bound, 1'b1, int'(stat.fill) <= HEAP_DEPTH, "fill count beyond depth")
    `TNH_ASSERT_NOW(a_empty_clean, done && res.empty_res,
        res.rank == 4'd0 && !res.is_last && res.out_weight == 32'd0, "empty result not clean")
    `TNH_ASSERT_NEXT(a_add_busy, start && !busy && req.req_type == REQ_ADD, busy,
        "add did not start work")
    `TNH_ASSERT_NEXT(a_clear_empties, start && !busy && req.req_type == REQ_CLEAR,
        stat.fill == 7'd0, "clear left entries")
    `TNH_ASSERT_NOW(a_busy_idle, 1'b1, busy == !stat.idle, "busy disagrees with idle state")

endmodule
